// ===== hw/rtl/date_to_epoch_seconds_core_macros.svh =====
// assertion helpers used by the checker file
`ifndef DATE_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define DATE_TO_EPOCH_SECONDS_CORE_MACROS_SVH

// antecedent implies consequent in the same or a later cycle
`define DTES_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DTES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtes_pkg.sv =====
package dtes_pkg;

  localparam int unsigned DAYS_W   = 18;
  localparam int unsigned SOD_W    = 17;
  localparam int unsigned EPOCH_W  = 35;
  localparam int unsigned OFFSET_W = 17;

  localparam logic [11:0] BASE_YEAR      = 12'd1900;
  localparam logic [8:0]  EPOCH_YEAR_OFS = 9'd70;
  // leap days counted before 1970: 1969/4 - 1969/100 + 1969/400
  localparam logic [DAYS_W-1:0] LEAP_DAYS_1970 = 18'd477;
  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR  = 18'd365;

  // x / 100 == (x * 5243) >> 19 for x below 43699
  localparam logic [24:0] DIV100_MUL = 25'd5243;
  localparam logic [11:0] HUNDRED    = 12'd100;

  localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 35'd86400;
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0]   SECS_PER_MIN  = 17'd60;

  localparam logic [OFFSET_W-1:0] ZONE_OFFSET_RESET = 17'd28800;

  localparam logic [3:0] MONTH_MAX  = 4'd11;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  // work handed from the day stage to the seconds stage
  typedef struct packed {
    logic              valid;
    logic              err;
    logic [DAYS_W-1:0] days;
    logic [SOD_W-1:0]  sod;
  } mid_t;

  // days before the first of the month
  function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    logic [8:0] extra;
    base  = 9'd0;
    extra = (leap && (mon > 4'd1)) ? 9'd1 : 9'd0;
    unique case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + extra;
  endfunction

endpackage

// ===== hw/rtl/dtes_day_calc.sv =====
module dtes_day_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [8:0]           years_since_1900,
  input  logic [3:0]           month_index,
  input  logic [4:0]           day_of_month,
  input  logic [4:0]           hour_of_day,
  input  logic [5:0]           minute_of_hour,
  input  logic [5:0]           second_of_minute,
  output dtes_pkg::mid_t       mid
);

  logic       vld;
  logic [8:0] yr;
  logic [3:0] mon;
  logic [4:0] day;
  logic [4:0] hr;
  logic [5:0] mi;
  logic [5:0] se;

  logic [11:0] year;
  logic [11:0] prev_year;
  logic [24:0] year_prod;
  logic [5:0]  year_div100;
  logic [11:0] year_hund;
  logic        leap;
  logic [9:0]  prev_div4;
  logic [24:0] prev_prod;
  logic [5:0]  prev_div100;
  logic [24:0] quad_prod;
  logic [5:0]  prev_div400;
  logic [dtes_pkg::DAYS_W-1:0] leap_days;
  logic [dtes_pkg::DAYS_W-1:0] year_days;
  logic [8:0]  month_days;
  logic        err;
  dtes_pkg::mid_t mid_next;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_valid;
    end
    yr  <= years_since_1900;
    mon <= month_index;
    day <= day_of_month;
    hr  <= hour_of_day;
    mi  <= minute_of_hour;
    se  <= second_of_minute;
  end

  // leap status of the full year
  always_comb begin
    year        = {3'b0, yr} + dtes_pkg::BASE_YEAR;
    prev_year   = year - 12'd1;
    year_prod   = {13'b0, year} * dtes_pkg::DIV100_MUL;
    year_div100 = year_prod[24:19];
    year_hund   = {6'b0, year_div100} * dtes_pkg::HUNDRED;
    leap        = (year[1:0] == 2'd0) &&
                  ((year != year_hund) || (year_div100[1:0] == 2'd0));
  end

  // leap days between 1970 and the start of the year
  always_comb begin
    prev_div4   = prev_year[11:2];
    prev_prod   = {13'b0, prev_year} * dtes_pkg::DIV100_MUL;
    prev_div100 = prev_prod[24:19];
    quad_prod   = {15'b0, prev_div4} * dtes_pkg::DIV100_MUL;
    prev_div400 = quad_prod[24:19];
    leap_days   = {8'b0, prev_div4} + {12'b0, prev_div400} - {12'b0, prev_div100}
                  - dtes_pkg::LEAP_DAYS_1970;
  end

  // day count and time of day
  always_comb begin
    year_days  = {9'b0, yr - dtes_pkg::EPOCH_YEAR_OFS} * dtes_pkg::DAYS_PER_YEAR;
    month_days = dtes_pkg::cum_days(mon, leap);
    err = (se > dtes_pkg::MINSEC_MAX) || (mi > dtes_pkg::MINSEC_MAX) ||
          (hr > dtes_pkg::HOUR_MAX) || (day == 5'd0) ||
          (mon > dtes_pkg::MONTH_MAX) || (yr < dtes_pkg::EPOCH_YEAR_OFS);
    mid_next.valid = vld;
    mid_next.err   = err;
    mid_next.days  = year_days + leap_days + {9'b0, month_days} + {13'b0, day}
                     - 18'd1;
    mid_next.sod   = ({12'b0, hr} * dtes_pkg::SECS_PER_HOUR) +
                     ({11'b0, mi} * dtes_pkg::SECS_PER_MIN) + {11'b0, se};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= mid_next.valid;
    end
    mid.err  <= mid_next.err;
    mid.days <= mid_next.days;
    mid.sod  <= mid_next.sod;
  end

endmodule

// ===== hw/rtl/dtes_sec_calc.sv =====
module dtes_sec_calc (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dtes_pkg::mid_t                        mid,
  input  logic signed [dtes_pkg::OFFSET_W-1:0]  zone_offset,
  output logic                                  done,
  output logic signed [dtes_pkg::EPOCH_W-1:0]   epoch_seconds,
  output logic                                  field_error
);

  logic [dtes_pkg::EPOCH_W-1:0]  day_secs;
  logic signed [dtes_pkg::EPOCH_W:0] total;
  logic [dtes_pkg::EPOCH_W-1:0]  epoch_next;

  // seconds of whole days plus time of day, less the zone offset; all ones on a field error
  always_comb begin
    day_secs = {17'b0, mid.days} * dtes_pkg::SECS_PER_DAY;
    total    = $signed({1'b0, day_secs}) + $signed({19'b0, mid.sod})
               - $signed({{19{zone_offset[dtes_pkg::OFFSET_W-1]}}, zone_offset});
    epoch_next = mid.err ? {dtes_pkg::EPOCH_W{1'b1}} : total[dtes_pkg::EPOCH_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid.valid;
    end
    epoch_seconds <= epoch_next;
    field_error   <= mid.err;
  end

endmodule

// ===== hw/rtl/date_to_epoch_seconds_core.sv =====
// Converts a local calendar date and time to epoch seconds, less the zone
// offset. A request is taken on any cycle with start high and busy low; busy
// is high only while rst is held, so one request can enter every cycle. The
// result passes the request register, the day-count stage and the result
// register, and appears with done high for exactly one cycle; there is no
// way to hold it, so the receiver must capture it on that cycle. An
// out-of-range field gives field_error high and epoch_seconds all ones.
// The zone offset register resets to eight hours and should be written only
// while no request is in flight.
module date_to_epoch_seconds_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [8:0]                            years_since_1900,
  input  logic [3:0]                            month_index,
  input  logic [4:0]                            day_of_month,
  input  logic [4:0]                            hour_of_day,
  input  logic [5:0]                            minute_of_hour,
  input  logic [5:0]                            second_of_minute,
  input  logic                                  cfg_wr_en,
  input  logic signed [dtes_pkg::OFFSET_W-1:0]  cfg_wr_data,
  output logic                                  done,
  output logic signed [dtes_pkg::EPOCH_W-1:0]   epoch_seconds,
  output logic                                  field_error
);

  logic signed [dtes_pkg::OFFSET_W-1:0] zone_offset_seconds;
  dtes_pkg::mid_t mid;

  assign busy = rst;

  // zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= dtes_pkg::ZONE_OFFSET_RESET;
    end else if (cfg_wr_en) begin
      zone_offset_seconds <= cfg_wr_data;
    end
  end

  dtes_day_calc u_day_calc (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start && !busy),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .mid              (mid)
  );

  dtes_sec_calc u_sec_calc (
    .clk           (clk),
    .rst           (rst),
    .mid           (mid),
    .zone_offset   (zone_offset_seconds),
    .done          (done),
    .epoch_seconds (epoch_seconds),
    .field_error   (field_error)
  );

endmodule

// ===== hw/rtl/dtes_checker.sv =====
`include "date_to_epoch_seconds_core_macros.svh"

module dtes_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic [5:0]                           second_of_minute,
  input logic [4:0]                           day_of_month,
  input logic                                 done,
  input logic signed [dtes_pkg::EPOCH_W-1:0]  epoch_seconds,
  input logic                                 field_error
);

  // every accepted request gives a result
  `DTES_ASSERT_IMPL(a_req_done, start && !busy, ##3 done, "request without result")

  // no result without an earlier accepted request
  `DTES_ASSERT_IMPL(a_done_req, done, $past(start && !busy, 3), "result without request")

  // an error result reads as minus one
  `DTES_ASSERT_IMPL(a_err_value, done && field_error, epoch_seconds == '1,
    "error result not all ones")

  // a bad second or a zero day is flagged
  `DTES_ASSERT_IMPL(a_bad_field, start && !busy &&
    ((second_of_minute > 6'd59) || (day_of_month == 5'd0)),
    ##3 (done && field_error), "bad field not flagged")

  // busy only while reset is held
  `DTES_ASSERT_NEXT(a_busy_low, 1'b1, !busy, "busy outside reset")

endmodule

bind date_to_epoch_seconds_core dtes_checker u_dtes_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .second_of_minute (second_of_minute),
  .day_of_month     (day_of_month),
  .done             (done),
  .epoch_seconds    (epoch_seconds),
  .field_error      (field_error)
);

// ===== tb/date_to_epoch_seconds_core_tb.sv =====
module date_to_epoch_seconds_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 520;
  localparam int unsigned DRAIN_CYCLES = 6;

  // one calendar request as driven on the ports
  typedef struct packed {
    logic [8:0] year_ofs;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_req_t;

  // one expected conversion result
  typedef struct packed {
    logic [dtes_pkg::EPOCH_W-1:0] epoch;
    logic                         err;
  } epoch_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic [8:0]                           years_since_1900;
  logic [3:0]                           month_index;
  logic [4:0]                           day_of_month;
  logic [4:0]                           hour_of_day;
  logic [5:0]                           minute_of_hour;
  logic [5:0]                           second_of_minute;
  logic                                 cfg_wr_en;
  logic signed [dtes_pkg::OFFSET_W-1:0] cfg_wr_data;
  logic                                 done;
  logic signed [dtes_pkg::EPOCH_W-1:0]  epoch_seconds;
  logic                                 field_error;

  logic signed [dtes_pkg::OFFSET_W-1:0] zone_offset_now;
  epoch_result_t                        expected_times[$];
  int unsigned                          error_count;
  int unsigned                          cycle_count;
  bit                                   no_idle;

  date_to_epoch_seconds_core dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .done             (done),
    .epoch_seconds    (epoch_seconds),
    .field_error      (field_error)
  );

  // 20 unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_times.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // gregorian leap rule
  function automatic bit is_leap_year(input longint yr);
    return ((yr % 400) == 0) || (((yr % 4) == 0) && ((yr % 100) != 0));
  endfunction

  // days from the start of year one to the start of the given year
  function automatic longint days_since_year_one(input longint yr);
    longint p;
    p = yr - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  // days from new year to the first of the month
  function automatic longint days_into_year(input int mon, input bit leap);
    longint total;
    total = 0;
    for (int m = 0; m < mon; m++) begin
      if (m == 1) total += leap ? 29 : 28;
      else if (m == 3 || m == 5 || m == 8 || m == 10) total += 30;
      else total += 31;
    end
    return total;
  endfunction

  // expected epoch seconds for one request under the current offset
  function automatic epoch_result_t predict_epoch(input date_req_t r,
      input logic signed [dtes_pkg::OFFSET_W-1:0] ofs);
    epoch_result_t res;
    longint        full_year;
    longint        days;
    longint        secs;
    if (r.second > 59 || r.minute > 59 || r.hour > 23 || r.day == 0 ||
        r.month > 11 || r.year_ofs < 70) begin
      res.epoch = '1;
      res.err   = 1'b1;
      return res;
    end
    full_year = longint'(r.year_ofs) + 1900;
    days = days_since_year_one(full_year) - days_since_year_one(1970);
    days += days_into_year(int'(r.month), is_leap_year(full_year));
    days += longint'(r.day) - 1;
    secs = days * 86400 + longint'(r.hour) * 3600 + longint'(r.minute) * 60
         + longint'(r.second) - longint'(ofs);
    res.epoch = secs[dtes_pkg::EPOCH_W-1:0];
    res.err   = 1'b0;
    return res;
  endfunction

  // predict on accepted requests, check each strobed result
  always @(posedge clk) begin
    epoch_result_t want;
    date_req_t     req;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_times.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: epoch %0d err %b", epoch_seconds, field_error);
        end else begin
          want = expected_times.pop_front();
          if (epoch_seconds !== want.epoch || field_error !== want.err) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected epoch %0d err %b, got epoch %0d err %b",
                       $signed(want.epoch), want.err, epoch_seconds, field_error);
          end
        end
      end
      if (start && !busy) begin
        req = '{years_since_1900, month_index, day_of_month, hour_of_day,
                minute_of_hour, second_of_minute};
        expected_times.push_back(predict_epoch(req, zone_offset_now));
      end
    end
  end

  // idle cycles with noise on the request fields
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start            <= 1'b0;
      years_since_1900 <= 9'($urandom);
      month_index      <= 4'($urandom);
      day_of_month     <= 5'($urandom);
      hour_of_day      <= 5'($urandom);
      minute_of_hour   <= 6'($urandom);
      second_of_minute <= 6'($urandom);
    end
  endtask

  // present one request and hold it until taken
  task automatic send_date(input date_req_t r);
    @(negedge clk);
    start            <= 1'b1;
    years_since_1900 <= r.year_ofs;
    month_index      <= r.month;
    day_of_month     <= r.day;
    hour_of_day      <= r.hour;
    minute_of_hour   <= r.minute;
    second_of_minute <= r.second;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!no_idle && $urandom_range(0, 99) < 4)
      idle_cycles($urandom_range(1, 5));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offset write, only with the pipeline empty
  task automatic set_zone_offset(input logic signed [dtes_pkg::OFFSET_W-1:0] ofs);
    wait_for_drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ofs;
    @(posedge clk);
    zone_offset_now = ofs;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic date_req_t valid_date();
    date_req_t r;
    r.year_ofs = 9'($urandom_range(70, 511));
    r.month    = 4'($urandom_range(0, 11));
    r.day      = 5'($urandom_range(1, 31));
    r.hour     = 5'($urandom_range(0, 23));
    r.minute   = 6'($urandom_range(0, 59));
    r.second   = 6'($urandom_range(0, 59));
    return r;
  endfunction

  // field limits, leap years and overflowing days under the reset offset
  task automatic test_field_limits();
    send_date('{9'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0});
    send_date('{9'd69, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0});
    send_date('{9'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0});
    send_date('{9'd511, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59});
    send_date('{9'd100, 4'd1, 5'd29, 5'd12, 6'd0, 6'd0});
    send_date('{9'd200, 4'd1, 5'd29, 5'd0, 6'd0, 6'd0});
    send_date('{9'd500, 4'd11, 5'd31, 5'd0, 6'd0, 6'd0});
    send_date('{9'd120, 4'd1, 5'd31, 5'd0, 6'd0, 6'd0});
    send_date('{9'd120, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0});
    send_date('{9'd120, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0});
    send_date('{9'd120, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0});
    send_date('{9'd120, 4'd5, 5'd1, 5'd24, 6'd0, 6'd0});
    send_date('{9'd120, 4'd5, 5'd1, 5'd31, 6'd0, 6'd0});
    send_date('{9'd120, 4'd5, 5'd1, 5'd0, 6'd60, 6'd0});
    send_date('{9'd120, 4'd5, 5'd1, 5'd0, 6'd63, 6'd0});
    send_date('{9'd120, 4'd5, 5'd1, 5'd0, 6'd0, 6'd60});
    send_date('{9'd120, 4'd5, 5'd1, 5'd0, 6'd0, 6'd63});
    send_date('{9'd511, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63});
  endtask

  // offset extremes, including a valid date that lands on minus one
  task automatic test_zone_offsets();
    logic signed [dtes_pkg::OFFSET_W-1:0] settings[6];
    settings = '{17'sd1, -17'sd50400, 17'sd50400, 17'sd0, -17'sd65536, 17'sd65535};
    foreach (settings[i]) begin
      set_zone_offset(settings[i]);
      send_date('{9'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0});
    end
    send_date('{9'd511, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59});
  endtask

  // mostly valid dates, some fully random fields, offset changes between phases
  task automatic test_random_dates();
    date_req_t   r;
    logic [31:0] ofs_raw;
    logic [63:0] rnd_wide;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 130 == 0) begin
        if ($urandom_range(0, 3) == 0)
          ofs_raw = $urandom;
        else
          ofs_raw = $urandom_range(0, 100800) - 50400;
        set_zone_offset(ofs_raw[dtes_pkg::OFFSET_W-1:0]);
      end
      no_idle = (i >= 260 && i < 400);
      if ($urandom_range(0, 99) < 80) begin
        r = valid_date();
      end else begin
        rnd_wide = {$urandom, $urandom};
        r = rnd_wide[$bits(date_req_t)-1:0];
      end
      send_date(r);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    years_since_1900 = '0;
    month_index      = '0;
    day_of_month     = '0;
    hour_of_day      = '0;
    minute_of_hour   = '0;
    second_of_minute = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    zone_offset_now  = dtes_pkg::ZONE_OFFSET_RESET;
    error_count      = 0;
    cycle_count      = 0;
    no_idle          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_limits();
    test_zone_offsets();
    test_random_dates();

    wait_for_drain();
    if (error_count == 0 && expected_times.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dtes_pkg.sv
hw/rtl/dtes_day_calc.sv
hw/rtl/dtes_sec_calc.sv
hw/rtl/date_to_epoch_seconds_core.sv
hw/rtl/dtes_checker.sv
tb/date_to_epoch_seconds_core_tb.sv
